[sv/acju_pkg.sv]
package acju_pkg;

  localparam int W    = 32;
  localparam int FRAC = 16;

  typedef logic signed [W-1:0] q_t;

  localparam q_t QMAX      = q_t'((64'd1 << (W - 1)) - 64'd1);
  localparam q_t QMIN      = q_t'(64'd1 << (W - 1));
  localparam q_t ONE       = q_t'(64'd1 << FRAC);
  localparam q_t EPS_RAW   = q_t'(((64'd1 << FRAC) + 64'd500) / 64'd1000);
  localparam q_t FORCE_LIM = q_t'(64'd3000 << FRAC);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SPRING = 2'd0;
  localparam kind_t KIND_ROPE   = 2'd1;
  localparam kind_t KIND_ROD    = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STAT_INACTIVE = 2'd0;
  localparam status_t STAT_CLOSE    = 2'd1;
  localparam status_t STAT_APPLIED  = 2'd2;

  typedef logic [7:0] reg_idx_t;
  localparam reg_idx_t REG_ANCHOR_X = 8'd0;
  localparam reg_idx_t REG_ANCHOR_Y = 8'd1;
  localparam reg_idx_t REG_REST_LEN = 8'd2;
  localparam reg_idx_t REG_STIFF    = 8'd3;
  localparam reg_idx_t REG_DAMP     = 8'd4;
  localparam reg_idx_t REG_KIND     = 8'd5;
  localparam reg_idx_t REG_DT       = 8'd6;
  localparam reg_idx_t REG_ENABLE   = 8'd7;

  typedef struct packed {
    q_t          anchor_x;
    q_t          anchor_y;
    logic [30:0] rest_len;
    logic [30:0] stiff;
    logic [19:0] damp;
    kind_t       kind;
    logic [16:0] dt;
    logic        enable;
  } cfg_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t vx;
    q_t vy;
    q_t fx;
    q_t fy;
  } body_t;

  typedef struct packed {
    logic        active;
    body_t       b;
    logic [30:0] mass;
  } in_item_t;

  typedef struct packed {
    body_t   b;
    status_t status;
    logic    limited;
  } res_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [W-1:0]    r;
    logic [FRAC-1:0] q;
  } dv_t;

  function automatic q_t sat64(input logic signed [63:0] v);
    if (v > 64'(QMAX)) return QMAX;
    if (v < 64'(QMIN)) return QMIN;
    return q_t'(v[W-1:0]);
  endfunction

  function automatic logic [W-1:0] mag(input q_t a);
    return a[W-1] ? W'(~a + 1'b1) : W'(a);
  endfunction

  // truncating fixed-point multiply on magnitudes, saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [W-1:0]        ua, ub;
    logic [2*W-1:0]      p;
    logic [2*W-FRAC-1:0] r, lim;
    logic                neg;
    q_t                  q;
    neg = a[W-1] ^ b[W-1];
    ua  = mag(a);
    ub  = mag(b);
    p   = (2*W)'(ua) * (2*W)'(ub);
    r   = p[2*W-1:FRAC];
    lim = (2*W-FRAC)'(QMAX) + (2*W-FRAC)'(neg);
    if (r > lim) return neg ? QMIN : QMAX;
    q = q_t'(r[W-1:0]);
    return neg ? -q : q;
  endfunction

  function automatic sq_t sq_step(input sq_t s, input logic [1:0] d);
    logic [35:0] cand, test;
    sq_t         o;
    cand = {s.rem, d};
    test = {2'b00, s.root, 2'b01};
    if (cand >= test) begin
      o.rem  = 34'(cand - test);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = cand[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_step(input dv_t s, input logic [W-1:0] den);
    logic [W:0] r2;
    logic       b;
    dv_t        o;
    r2 = {s.r, 1'b0};
    b  = (r2 >= {1'b0, den});
    if (b) r2 = r2 - {1'b0, den};
    o.r = r2[W-1:0];
    o.q = {s.q[FRAC-2:0], b};
    return o;
  endfunction

endpackage

[sv/acju_ifs.sv]
interface acju_in_if;
  logic               valid;
  logic               ready;
  logic               body_active;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic [30:0]        body_mass;
  modport source(output valid, body_active, pos_x, pos_y, vel_x, vel_y, force_x, force_y,
                 body_mass, input ready);
  modport sink(input valid, body_active, pos_x, pos_y, vel_x, vel_y, force_x, force_y,
               body_mass, output ready);
endinterface

interface acju_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_force_x;
  logic signed [31:0] out_force_y;
  logic [1:0]         joint_status;
  logic               force_limited;
  modport source(output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_force_x,
                 out_force_y, joint_status, force_limited, input ready);
  modport sink(input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_force_x,
               out_force_y, joint_status, force_limited, output ready);
endinterface

interface acju_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/acju_isqrt.sv]
module acju_isqrt import acju_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  logic [63:0]       rad_a,
  input  logic [63:0]       rad_b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [31:0]       root_a,
  output logic [31:0]       root_b,
  output logic [SIDE_W-1:0] side_out
);

  localparam int N = 32;

  sq_t               pa [N];
  sq_t               pb [N];
  sq_t               qa_r [N];
  sq_t               qb_r [N];
  logic [63:0]       ra_pre [N];
  logic [63:0]       rb_pre [N];
  logic [63:0]       ra_r [N-1];
  logic [63:0]       rb_r [N-1];
  logic [SIDE_W-1:0] sd_pre [N];
  logic [SIDE_W-1:0] sd_r [N];
  logic              v_pre [N];
  logic              v_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    if (k == 0) begin : g_first
      assign pa[k]     = '0;
      assign pb[k]     = '0;
      assign ra_pre[k] = rad_a;
      assign rb_pre[k] = rad_b;
      assign sd_pre[k] = side_in;
      assign v_pre[k]  = v_in;
    end else begin : g_next
      assign pa[k]     = qa_r[k-1];
      assign pb[k]     = qb_r[k-1];
      assign ra_pre[k] = ra_r[k-1];
      assign rb_pre[k] = rb_r[k-1];
      assign sd_pre[k] = sd_r[k-1];
      assign v_pre[k]  = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qa_r[k] <= sq_step(pa[k], ra_pre[k][63:62]);
        qb_r[k] <= sq_step(pb[k], rb_pre[k][63:62]);
        sd_r[k] <= sd_pre[k];
      end
    end

    if (k < N - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          ra_r[k] <= {ra_pre[k][61:0], 2'b00};
          rb_r[k] <= {rb_pre[k][61:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_pre[k];
      end
    end
  end

  assign v_out    = v_r[N-1];
  assign root_a   = qa_r[N-1].root;
  assign root_b   = qb_r[N-1].root;
  assign side_out = sd_r[N-1];

endmodule

[sv/acju_fdiv.sv]
module acju_fdiv import acju_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  logic [W-1:0]      num_a,
  input  logic [W-1:0]      num_b,
  input  logic [W-1:0]      den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [FRAC-1:0]   quo_a,
  output logic [FRAC-1:0]   quo_b,
  output logic [SIDE_W-1:0] side_out
);

  localparam int N = FRAC;

  dv_t               pa [N];
  dv_t               pb [N];
  dv_t               qa_r [N];
  dv_t               qb_r [N];
  logic [W-1:0]      dn_pre [N];
  logic [W-1:0]      dn_r [N-1];
  logic [SIDE_W-1:0] sd_pre [N];
  logic [SIDE_W-1:0] sd_r [N];
  logic              v_pre [N];
  logic              v_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    if (k == 0) begin : g_first
      assign pa[k]     = '{r: num_a, q: '0};
      assign pb[k]     = '{r: num_b, q: '0};
      assign dn_pre[k] = den;
      assign sd_pre[k] = side_in;
      assign v_pre[k]  = v_in;
    end else begin : g_next
      assign pa[k]     = qa_r[k-1];
      assign pb[k]     = qb_r[k-1];
      assign dn_pre[k] = dn_r[k-1];
      assign sd_pre[k] = sd_r[k-1];
      assign v_pre[k]  = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qa_r[k] <= div_step(pa[k], dn_pre[k]);
        qb_r[k] <= div_step(pb[k], dn_pre[k]);
        sd_r[k] <= sd_pre[k];
      end
    end

    if (k < N - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          dn_r[k] <= dn_pre[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_pre[k];
      end
    end
  end

  assign v_out    = v_r[N-1];
  assign quo_a    = qa_r[N-1].q;
  assign quo_b    = qb_r[N-1].q;
  assign side_out = sd_r[N-1];

endmodule

[sv/acju_core.sv]
module acju_core import acju_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_v,
  input  in_item_t in_d,
  input  cfg_t     cfg,
  output logic     out_v,
  output res_t     out_d
);

  typedef struct packed {
    body_t       b;
    logic        go;
    logic        sh;
    logic        negx;
    logic        negy;
    logic [31:0] ax;
    logic [31:0] ay;
  } sd_t;

  typedef struct packed {
    body_t       b;
    logic        go;
    logic        close;
    logic        negx;
    logic        negy;
    logic        satx;
    logic        saty;
    logic [30:0] len;
    q_t          crit;
  } dd_t;

  typedef struct packed {
    body_t b;
    logic  go, close, longer;
    q_t    dirx, diry, over, damp, pvx, pvy, fdt;
  } a_t;

  typedef struct packed {
    body_t b;
    logic  go, close, longer;
    q_t    dirx, diry, damp, vp, t1, ox, oy, factor;
  } b_t;

  typedef struct packed {
    body_t b;
    logic  go, close, longer, vpneg;
    q_t    dirx, diry, factor, t1, t2, rx, ry, px, py;
  } c_t;

  typedef struct packed {
    body_t b;
    logic  go, close, longer, vpneg, lim;
    q_t    dirx, diry, factor, total, b2x, b2y, wx, wy, px, py;
  } d_t;

  typedef struct packed {
    body_t b;
    logic  go, close, longer, vpneg, lim;
    q_t    ftx, fty, b3x, b3y, rvx, rvy, wx, wy, px, py;
  } e_t;

  q_t    s1_dx, s1_dy;
  sd_t   s1_r, s2_r;
  logic  [61:0] km_r;
  logic  [63:0] sq_r, km2_r;
  logic  v1_r, v2_r, v3_r, va_r, vb_r, vc_r, vd_r, ve_r;
  logic  [30:0] hx, hy;

  logic  sq_v;
  logic  [31:0] root_l, root_k;
  sd_t   sq_side;
  logic  [32:0] len33, crit33;
  logic  [30:0] len_c;
  q_t    crit_c;

  dd_t   s3_r;
  logic  [W-1:0] nx_r, ny_r;

  logic  dv_v;
  logic  [FRAC-1:0] qx, qy;
  dd_t   dv_side;
  q_t    dmx, dmy, dirx, diry, len_q, rest_q;

  a_t    a_r;
  b_t    b_r;
  c_t    c_r;
  d_t    d_r;
  e_t    e_r;
  q_t    tsum, damp_q, dt_q, stiff_q;
  q_t    f_fx, f_fy, f_vx, f_vy;

  assign damp_q  = q_t'(cfg.damp);
  assign dt_q    = q_t'(cfg.dt);
  assign stiff_q = q_t'(cfg.stiff);
  assign rest_q  = q_t'(cfg.rest_len);

  // offset to anchor, range shift and k*m
  assign s1_dx = sat64(64'(cfg.anchor_x) - 64'(in_d.b.x));
  assign s1_dy = sat64(64'(cfg.anchor_y) - 64'(in_d.b.y));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.b    <= in_d.b;
      s1_r.go   <= in_d.active & cfg.enable & (cfg.kind != KIND_NONE);
      s1_r.negx <= s1_dx[W-1];
      s1_r.negy <= s1_dy[W-1];
      s1_r.ax   <= mag(s1_dx);
      s1_r.ay   <= mag(s1_dy);
      s1_r.sh   <= mag(s1_dx) >= 32'h8000_0000 || mag(s1_dy) >= 32'h8000_0000;
      km_r      <= 62'(cfg.stiff) * 62'(in_d.mass);
    end
  end

  assign hx = s1_r.sh ? s1_r.ax[31:1] : s1_r.ax[30:0];
  assign hy = s1_r.sh ? s1_r.ay[31:1] : s1_r.ay[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= s1_r;
      sq_r  <= 64'(hx) * 64'(hx) + 64'(hy) * 64'(hy);
      km2_r <= 64'(km_r);
    end
  end

  acju_isqrt #(.SIDE_W($bits(sd_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v2_r),
    .rad_a    (sq_r),
    .rad_b    (km2_r),
    .side_in  (s2_r),
    .v_out    (sq_v),
    .root_a   (root_l),
    .root_b   (root_k),
    .side_out (sq_side)
  );

  assign len33  = sq_side.sh ? {root_l, 1'b0} : {1'b0, root_l};
  assign len_c  = (len33 > 33'(QMAX)) ? QMAX[30:0] : len33[30:0];
  assign crit33 = {root_k, 1'b0};
  assign crit_c = (crit33 > 33'(QMAX)) ? QMAX : q_t'(crit33[31:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.b     <= sq_side.b;
      s3_r.go    <= sq_side.go;
      s3_r.close <= len_c < EPS_RAW[30:0];
      s3_r.negx  <= sq_side.negx;
      s3_r.negy  <= sq_side.negy;
      s3_r.satx  <= sq_side.ax >= {1'b0, len_c};
      s3_r.saty  <= sq_side.ay >= {1'b0, len_c};
      s3_r.len   <= len_c;
      s3_r.crit  <= crit_c;
      nx_r       <= sq_side.ax;
      ny_r       <= sq_side.ay;
    end
  end

  acju_fdiv #(.SIDE_W($bits(dd_t))) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v3_r),
    .num_a    (nx_r),
    .num_b    (ny_r),
    .den      ({1'b0, s3_r.len}),
    .side_in  (s3_r),
    .v_out    (dv_v),
    .quo_a    (qx),
    .quo_b    (qy),
    .side_out (dv_side)
  );

  assign dmx   = dv_side.satx ? ONE : q_t'(qx);
  assign dmy   = dv_side.saty ? ONE : q_t'(qy);
  assign dirx  = dv_side.negx ? -dmx : dmx;
  assign diry  = dv_side.negy ? -dmy : dmy;
  assign len_q = q_t'(dv_side.len);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.b      <= dv_side.b;
      a_r.go     <= dv_side.go;
      a_r.close  <= dv_side.close;
      a_r.longer <= len_q > rest_q;
      a_r.dirx   <= dirx;
      a_r.diry   <= diry;
      a_r.over   <= sat64(64'(len_q) - 64'(rest_q));
      a_r.damp   <= qmul(dv_side.crit, damp_q);
      a_r.pvx    <= qmul(dv_side.b.vx, dirx);
      a_r.pvy    <= qmul(dv_side.b.vy, diry);
      a_r.fdt    <= qmul(damp_q, dt_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r.b      <= a_r.b;
      b_r.go     <= a_r.go;
      b_r.close  <= a_r.close;
      b_r.longer <= a_r.longer;
      b_r.dirx   <= a_r.dirx;
      b_r.diry   <= a_r.diry;
      b_r.damp   <= a_r.damp;
      b_r.vp     <= sat64(64'(a_r.pvx) + 64'(a_r.pvy));
      b_r.t1     <= qmul(stiff_q, a_r.over);
      b_r.ox     <= qmul(a_r.dirx, a_r.over);
      b_r.oy     <= qmul(a_r.diry, a_r.over);
      b_r.factor <= sat64(64'(ONE) - 64'(a_r.fdt));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r.b      <= b_r.b;
      c_r.go     <= b_r.go;
      c_r.close  <= b_r.close;
      c_r.longer <= b_r.longer;
      c_r.vpneg  <= b_r.vp[W-1];
      c_r.dirx   <= b_r.dirx;
      c_r.diry   <= b_r.diry;
      c_r.factor <= b_r.factor;
      c_r.t1     <= b_r.t1;
      c_r.t2     <= qmul(b_r.damp, b_r.vp);
      c_r.rx     <= qmul(b_r.vp, b_r.dirx);
      c_r.ry     <= qmul(b_r.vp, b_r.diry);
      c_r.px     <= sat64(64'(b_r.b.x) + 64'(b_r.ox));
      c_r.py     <= sat64(64'(b_r.b.y) + 64'(b_r.oy));
    end
  end

  assign tsum = sat64(64'(c_r.t1) + 64'(c_r.t2));

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.b      <= c_r.b;
      d_r.go     <= c_r.go;
      d_r.close  <= c_r.close;
      d_r.longer <= c_r.longer;
      d_r.vpneg  <= c_r.vpneg;
      d_r.lim    <= (tsum > FORCE_LIM) || (tsum < -FORCE_LIM);
      d_r.total  <= (tsum > FORCE_LIM) ? FORCE_LIM : (tsum < -FORCE_LIM) ? -FORCE_LIM : tsum;
      d_r.dirx   <= c_r.dirx;
      d_r.diry   <= c_r.diry;
      d_r.factor <= c_r.factor;
      d_r.b2x    <= qmul(c_r.rx, damp_q);
      d_r.b2y    <= qmul(c_r.ry, damp_q);
      d_r.wx     <= sat64(64'(c_r.b.vx) - 64'(c_r.rx));
      d_r.wy     <= sat64(64'(c_r.b.vy) - 64'(c_r.ry));
      d_r.px     <= c_r.px;
      d_r.py     <= c_r.py;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r.b      <= d_r.b;
      e_r.go     <= d_r.go;
      e_r.close  <= d_r.close;
      e_r.longer <= d_r.longer;
      e_r.vpneg  <= d_r.vpneg;
      e_r.lim    <= d_r.lim;
      e_r.ftx    <= qmul(d_r.total, d_r.dirx);
      e_r.fty    <= qmul(d_r.total, d_r.diry);
      e_r.b3x    <= qmul(d_r.b2x, dt_q);
      e_r.b3y    <= qmul(d_r.b2y, dt_q);
      e_r.rvx    <= qmul(d_r.wx, d_r.factor);
      e_r.rvy    <= qmul(d_r.wy, d_r.factor);
      e_r.wx     <= d_r.wx;
      e_r.wy     <= d_r.wy;
      e_r.px     <= d_r.px;
      e_r.py     <= d_r.py;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= sq_v;
      va_r <= dv_v;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  // spring: force accumulate and radial velocity bleed (x10)
  assign f_fx = sat64(64'(e_r.b.fx) + 64'(e_r.ftx));
  assign f_fy = sat64(64'(e_r.b.fy) + 64'(e_r.fty));
  assign f_vx = sat64(64'(e_r.b.vx) - 64'(sat64(64'(e_r.b3x) * 64'sd10)));
  assign f_vy = sat64(64'(e_r.b.vy) - 64'(sat64(64'(e_r.b3y) * 64'sd10)));

  always_comb begin
    out_d.b       = e_r.b;
    out_d.status  = STAT_INACTIVE;
    out_d.limited = 1'b0;
    if (e_r.go) begin
      if (e_r.close) begin
        out_d.status = STAT_CLOSE;
      end else begin
        out_d.status = STAT_APPLIED;
        unique case (cfg.kind)
          KIND_SPRING: begin
            out_d.b.fx    = f_fx;
            out_d.b.fy    = f_fy;
            out_d.b.vx    = f_vx;
            out_d.b.vy    = f_vy;
            out_d.limited = e_r.lim;
          end
          KIND_ROPE: begin
            if (e_r.longer) begin
              out_d.b.x = e_r.px;
              out_d.b.y = e_r.py;
              if (e_r.vpneg) begin
                out_d.b.vx = e_r.wx;
                out_d.b.vy = e_r.wy;
              end
            end
          end
          KIND_ROD: begin
            out_d.b.x  = e_r.px;
            out_d.b.y  = e_r.py;
            out_d.b.vx = e_r.rvx;
            out_d.b.vy = e_r.rvy;
          end
          default: begin
            out_d.status = STAT_INACTIVE;
          end
        endcase
      end
    end
  end

  assign out_v = ve_r;

endmodule

[sv/anchor_joint_constraint_unit.sv]
// Anchor joint unit: applies one spring, rope or rod joint to a stream of body
// states in signed Q16.16. A body is accepted every cycle unless the input stalls; the
// pipeline depth is set by the 32-stage square root (one result bit per
// stage) and the 16-stage direction quotient (one fraction bit per stage). A two-entry
// output buffer keeps input ready registered; input stalls only while that buffer is
// full. Configuration writes are accepted every cycle and must be issued while no
// body is in flight.
module anchor_joint_constraint_unit import acju_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  acju_cfg_if.sink   cfg_bus,
  acju_in_if.sink    in_bus,
  acju_out_if.source out_bus
);

  cfg_t     cfg_r;
  in_item_t in_d;
  res_t     core_d, out_r, sk_r;
  logic     core_v, en, out_valid_r, sk_valid_r, out_take;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{anchor_x: '0, anchor_y: '0, rest_len: '0, stiff: '0, damp: '0,
                 kind: KIND_SPRING, dt: 17'd1092, enable: 1'b0};
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_ANCHOR_X: cfg_r.anchor_x <= q_t'(cfg_bus.data);
        REG_ANCHOR_Y: cfg_r.anchor_y <= q_t'(cfg_bus.data);
        REG_REST_LEN: cfg_r.rest_len <= cfg_bus.data[30:0];
        REG_STIFF:    cfg_r.stiff    <= cfg_bus.data[30:0];
        REG_DAMP:     cfg_r.damp     <= cfg_bus.data[19:0];
        REG_KIND:     cfg_r.kind     <= cfg_bus.data[1:0];
        REG_DT:       cfg_r.dt       <= cfg_bus.data[16:0];
        REG_ENABLE:   cfg_r.enable   <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_d.active = in_bus.body_active;
  assign in_d.b.x    = in_bus.pos_x;
  assign in_d.b.y    = in_bus.pos_y;
  assign in_d.b.vx   = in_bus.vel_x;
  assign in_d.b.vy   = in_bus.vel_y;
  assign in_d.b.fx   = in_bus.force_x;
  assign in_d.b.fy   = in_bus.force_y;
  assign in_d.mass   = in_bus.body_mass;

  assign en           = !sk_valid_r;
  assign in_bus.ready = en;

  acju_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_bus.valid),
    .in_d  (in_d),
    .cfg   (cfg_r),
    .out_v (core_v),
    .out_d (core_d)
  );

  assign out_take = out_valid_r & out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (sk_valid_r) begin
      if (out_take) begin
        out_r      <= sk_r;
        sk_valid_r <= 1'b0;
      end
    end else if (core_v) begin
      if (!out_valid_r || out_take) begin
        out_r       <= core_d;
        out_valid_r <= 1'b1;
      end else begin
        sk_r       <= core_d;
        sk_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_pos_x     = out_r.b.x;
  assign out_bus.out_pos_y     = out_r.b.y;
  assign out_bus.out_vel_x     = out_r.b.vx;
  assign out_bus.out_vel_y     = out_r.b.vy;
  assign out_bus.out_force_x   = out_r.b.fx;
  assign out_bus.out_force_y   = out_r.b.fy;
  assign out_bus.joint_status  = out_r.status;
  assign out_bus.force_limited = out_r.limited;

endmodule

[sv/acju_checker.sv]
module acju_checker import acju_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic [1:0]  joint_status,
  input logic        force_limited
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x))
    else $error("output request changed while stalled");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && force_limited |-> joint_status == STAT_APPLIED)
    else $error("force limit flagged on a pass-through result");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind anchor_joint_constraint_unit acju_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_pos_x     (out_bus.out_pos_x),
  .joint_status  (out_bus.joint_status),
  .force_limited (out_bus.force_limited)
);

[verif/tb_top.sv]
module tb_top;
  import acju_pkg::*;

  localparam longint QX = 64'sd2147483647;
  localparam longint QN = -64'sd2147483648;
  localparam longint ONE_RAW = 64'sd65536;
  localparam longint EPS_Q = 64'sd66;
  localparam longint FLIM = 64'sd3000 * 64'sd65536;
  localparam int LATENCY = 70;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  acju_cfg_if cfg_bus();
  acju_in_if in_bus();
  acju_out_if out_bus();

  anchor_joint_constraint_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_bus(cfg_bus), .in_bus(in_bus), .out_bus(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // joint settings as the block should hold them
  longint jt_ax, jt_ay, jt_rest, jt_stiff, jt_damp, jt_dt;
  kind_t jt_kind;
  logic jt_en;

  res_t body_q[$];
  int idle_mode = IDLE_NONE;
  int mismatches = 0;
  int cycles = 0;

  function automatic longint sat(longint v);
    if (v > QX) return QX;
    if (v < QN) return QN;
    return v;
  endfunction

  function automatic longint unsigned absval(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint fmul(longint a, longint b);
    logic [127:0] p;
    logic neg;
    longint unsigned lim;
    neg = (a < 0) != (b < 0);
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    p = p >> FRAC;
    lim = 64'd2147483647 + neg;
    if (p > {64'd0, lim}) return neg ? QN : QX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_dir(longint num, longint unsigned den);
    longint unsigned n, q, r;
    n = absval(num);
    q = 0;
    if (n >= den) q = ONE_RAW;
    else begin
      r = n;
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
    end
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic res_t joint_response(in_item_t it);
    longint x, y, vx, vy, fx, fy, mass, dx, dy, l, dirx, diry, vp, over;
    longint stretch, crit, dmp, total, bx, by, factor;
    longint unsigned ax, ay, len;
    int s;
    res_t r;
    x = it.b.x; y = it.b.y; vx = it.b.vx; vy = it.b.vy; fx = it.b.fx; fy = it.b.fy;
    mass = longint'(it.mass);
    r.status = STAT_INACTIVE;
    r.limited = 1'b0;
    if (it.active && jt_en && jt_kind != KIND_NONE) begin
      dx = sat(jt_ax - x);
      dy = sat(jt_ay - y);
      ax = absval(dx);
      ay = absval(dy);
      s = 0;
      while ((ax >> s) >= 64'h80000000 || (ay >> s) >= 64'h80000000) s++;
      len = floor_root((ax >> s) * (ax >> s) + (ay >> s) * (ay >> s)) << s;
      if (len > QX) len = QX;
      if (longint'(len) < EPS_Q) r.status = STAT_CLOSE;
      else begin
        dirx = unit_dir(dx, len);
        diry = unit_dir(dy, len);
        l = longint'(len);
        r.status = STAT_APPLIED;
        if (jt_kind == KIND_SPRING) begin
          stretch = sat(l - jt_rest);
          crit = sat(2 * longint'(floor_root(jt_stiff * mass)));
          dmp = fmul(crit, jt_damp);
          vp = sat(fmul(vx, dirx) + fmul(vy, diry));
          total = sat(fmul(jt_stiff, stretch) + fmul(dmp, vp));
          if (total > FLIM) begin
            total = FLIM;
            r.limited = 1'b1;
          end
          if (total < -FLIM) begin
            total = -FLIM;
            r.limited = 1'b1;
          end
          fx = sat(fx + fmul(total, dirx));
          fy = sat(fy + fmul(total, diry));
          bx = sat(fmul(fmul(fmul(vp, dirx), jt_damp), jt_dt) * 10);
          by = sat(fmul(fmul(fmul(vp, diry), jt_damp), jt_dt) * 10);
          vx = sat(vx - bx);
          vy = sat(vy - by);
        end else if (jt_kind == KIND_ROPE) begin
          if (l > jt_rest) begin
            over = sat(l - jt_rest);
            x = sat(x + fmul(dirx, over));
            y = sat(y + fmul(diry, over));
            vp = sat(fmul(vx, dirx) + fmul(vy, diry));
            if (vp < 0) begin
              vx = sat(vx - fmul(vp, dirx));
              vy = sat(vy - fmul(vp, diry));
            end
          end
        end else begin
          over = sat(l - jt_rest);
          x = sat(x + fmul(dirx, over));
          y = sat(y + fmul(diry, over));
          vp = sat(fmul(vx, dirx) + fmul(vy, diry));
          vx = sat(vx - fmul(vp, dirx));
          vy = sat(vy - fmul(vp, diry));
          factor = sat(ONE_RAW - fmul(jt_damp, jt_dt));
          vx = fmul(vx, factor);
          vy = fmul(vy, factor);
        end
      end
    end
    r.b.x = x[31:0]; r.b.y = y[31:0]; r.b.vx = vx[31:0]; r.b.vy = vy[31:0];
    r.b.fx = fx[31:0]; r.b.fy = fy[31:0];
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_ANCHOR_X: jt_ax = longint'(signed'(val));
      REG_ANCHOR_Y: jt_ay = longint'(signed'(val));
      REG_REST_LEN: jt_rest = longint'(val[30:0]);
      REG_STIFF: jt_stiff = longint'(val[30:0]);
      REG_DAMP: jt_damp = longint'(val[19:0]);
      REG_KIND: jt_kind = val[1:0];
      REG_DT: jt_dt = longint'(val[16:0]);
      REG_ENABLE: jt_en = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic drain();
    while (body_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic setup(longint axv, longint ayv, longint rest, longint k, longint d,
                       kind_t kd, longint dt, logic en);
    drain();
    write_reg(REG_ANCHOR_X, axv[31:0]);
    write_reg(REG_ANCHOR_Y, ayv[31:0]);
    write_reg(REG_REST_LEN, {1'b0, rest[30:0]});
    write_reg(REG_STIFF, {1'b0, k[30:0]});
    write_reg(REG_DAMP, {12'd0, d[19:0]});
    write_reg(REG_KIND, {30'd0, kd});
    write_reg(REG_DT, {15'd0, dt[16:0]});
    write_reg(REG_ENABLE, {31'd0, en});
  endtask

  function automatic bit pick(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic send_body(in_item_t it, bit typed, status_t st);
    res_t e;
    while ((idle_mode == IDLE_SEND && pick(51)) || (idle_mode == IDLE_BOTH && pick(28))) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.body_active = it.active;
    in_bus.pos_x = it.b.x; in_bus.pos_y = it.b.y;
    in_bus.vel_x = it.b.vx; in_bus.vel_y = it.b.vy;
    in_bus.force_x = it.b.fx; in_bus.force_y = it.b.fy;
    in_bus.body_mass = it.mass;
    do @(posedge clk); while (!in_bus.ready);
    if (typed) begin
      e.b = it.b;
      e.status = st;
      e.limited = 1'b0;
    end else begin
      e = joint_response(it);
    end
    body_q.push_back(e);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (idle_mode == IDLE_RECV) out_bus.ready = !pick(51);
    else if (idle_mode == IDLE_BOTH) out_bus.ready = !pick(28);
    else out_bus.ready = 1'b1;
  end

  always @(posedge clk) begin
    res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.b.x = out_bus.out_pos_x; got.b.y = out_bus.out_pos_y;
      got.b.vx = out_bus.out_vel_x; got.b.vy = out_bus.out_vel_y;
      got.b.fx = out_bus.out_force_x; got.b.fy = out_bus.out_force_y;
      got.status = out_bus.joint_status;
      got.limited = out_bus.force_limited;
      if (body_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = body_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %h %h %h st %0d lim %0d, got %h %h %h %h %h %h st %0d lim %0d",
              want.b.x, want.b.y, want.b.vx, want.b.vy, want.b.fx, want.b.fy,
              want.status, want.limited, got.b.x, got.b.y, got.b.vx, got.b.vy,
              got.b.fx, got.b.fy, got.status, got.limited);
        end
      end
    end
  end

  typedef struct {
    int       phase;
    bit       typed;
    status_t  st;
    in_item_t it;
  } row_t;

  function automatic in_item_t mk(logic act, longint x, longint y, longint vx, longint vy,
                                  longint fx, longint fy, longint m);
    in_item_t it;
    it.active = act;
    it.b.x = x[31:0]; it.b.y = y[31:0]; it.b.vx = vx[31:0]; it.b.vy = vy[31:0];
    it.b.fx = fx[31:0]; it.b.fy = fy[31:0];
    it.mass = m[30:0];
    return it;
  endfunction

  function automatic longint near(longint c, int span);
    return sat(c + longint'($urandom_range(2 * span)) - span);
  endfunction

  function automatic longint anyq();
    return longint'(signed'(32'($urandom)));
  endfunction

  function automatic in_item_t rand_body();
    in_item_t it;
    if (pick(80)) begin
      it = mk(pick(92), near(jt_ax, 20 << 16), near(jt_ay, 20 << 16),
              near(0, 100 << 16), near(0, 100 << 16), near(0, 500 << 16),
              near(0, 500 << 16), longint'($urandom_range(1, 100 << 16)));
      if (pick(5)) it.b.x = jt_ax[31:0];
    end else begin
      it = mk(1'($urandom_range(1)), anyq(), anyq(), anyq(), anyq(), anyq(), anyq(),
              longint'($urandom_range(1, 32'h7fffffff)));
    end
    return it;
  endfunction

  row_t rows[$];
  int cur;

  initial begin
    cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
    in_bus.valid = 1'b0; in_bus.body_active = 1'b0;
    in_bus.pos_x = '0; in_bus.pos_y = '0; in_bus.vel_x = '0; in_bus.vel_y = '0;
    in_bus.force_x = '0; in_bus.force_y = '0; in_bus.body_mass = '0;
    jt_ax = 0; jt_ay = 0; jt_rest = 0; jt_stiff = 0; jt_damp = 0;
    jt_kind = KIND_SPRING; jt_dt = 1092; jt_en = 1'b0;

    // after reset the joint is off: bodies pass through
    rows.push_back('{0, 1, STAT_INACTIVE, mk(1, QX, QN, QN, QX, -1, 1, 1)});
    rows.push_back('{0, 1, STAT_INACTIVE, mk(0, 5 << 16, 0, 1 << 16, 0, 0, 0, 1 << 16)});
    // spring
    rows.push_back('{1, 1, STAT_CLOSE, mk(1, 0, 0, 7 << 16, 0, 3, 4, 1 << 16)});
    rows.push_back('{1, 1, STAT_CLOSE, mk(1, 30, 50, -1, 9, 0, 0, 1 << 16)});
    rows.push_back('{1, 0, STAT_APPLIED, mk(1, 66, 0, 0, 0, 0, 0, 1 << 16)});
    rows.push_back('{1, 0, STAT_APPLIED, mk(1, 3 << 16, 4 << 16, 2 << 16, -1 << 16, 0, 0, 2 << 16)});
    rows.push_back('{1, 0, STAT_APPLIED, mk(1, QN, QN, QX, QN, QX, QN, 32'h7fffffff)});
    rows.push_back('{1, 0, STAT_APPLIED, mk(1, QX, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{1, 0, STAT_APPLIED, mk(1, 500 << 16, -900 << 16, 50 << 16, 0, 0, 0, 9 << 16)});
    rows.push_back('{1, 1, STAT_INACTIVE, mk(0, 9 << 16, 9 << 16, 0, 0, 0, 0, 1 << 16)});
    // rope
    rows.push_back('{2, 0, STAT_APPLIED, mk(1, 1 << 16, 0, -4 << 16, 0, 0, 0, 1 << 16)});
    rows.push_back('{2, 0, STAT_APPLIED, mk(1, 8 << 16, 6 << 16, 3 << 16, 2 << 16, 0, 0, 1 << 16)});
    rows.push_back('{2, 0, STAT_APPLIED, mk(1, -8 << 16, 6 << 16, 3 << 16, 2 << 16, 0, 0, 1 << 16)});
    rows.push_back('{2, 0, STAT_APPLIED, mk(1, QN, QX, QN, QN, 0, 0, 1 << 16)});
    // rod
    rows.push_back('{3, 0, STAT_APPLIED, mk(1, 1 << 16, 1 << 16, 5 << 16, 5 << 16, 0, 0, 1 << 16)});
    rows.push_back('{3, 0, STAT_APPLIED, mk(1, -20 << 16, 3 << 16, -7 << 16, 1 << 16, 1, 2, 1 << 16)});
    rows.push_back('{3, 0, STAT_APPLIED, mk(1, QX, QX, QX, QX, QX, QX, 32'h7fffffff)});
    // unused joint kind behaves as a disabled joint
    rows.push_back('{4, 1, STAT_INACTIVE, mk(1, 3 << 16, 4 << 16, 1, 2, 3, 4, 1 << 16)});
    // anchor at the far corner
    rows.push_back('{5, 0, STAT_APPLIED, mk(1, QN, QN, 1 << 16, 1 << 16, 0, 0, 1 << 16)});
    rows.push_back('{5, 1, STAT_CLOSE, mk(1, QX, QX, 1 << 16, 1 << 16, 0, 0, 1 << 16)});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur) begin
        cur = rows[i].phase;
        case (cur)
          1: setup(0, 0, 1 << 16, 10 << 16, 32768, KIND_SPRING, 1092, 1);
          2: setup(0, 0, 5 << 16, 0, 0, KIND_ROPE, 1092, 1);
          3: setup(0, 0, 2 << 16, 0, 655360, KIND_ROD, 65536, 1);
          4: setup(0, 0, 1 << 16, 1 << 16, 0, KIND_NONE, 1, 1);
          default: setup(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 20'hfffff,
                         KIND_SPRING, 17'h1ffff, 1);
        endcase
      end
      send_body(rows[i].it, rows[i].typed, rows[i].st);
    end

    for (int p = 0; p < 8; p++) begin
      kind_t kd;
      kd = kind_t'(p % 3);
      if (p == 0)
        setup(32'h80000000, 32'h80000000, 0, 31'h7fffffff, 655360, kd, 65536, 1);
      else if (p == 1)
        setup(0, 0, 0, 0, 0, kd, 1, 1);
      else if (p == 7)
        setup(longint'($urandom), longint'($urandom), longint'($urandom), longint'($urandom),
              longint'($urandom), KIND_NONE, longint'($urandom), 0);
      else
        setup(near(0, 1000 << 16), near(0, 1000 << 16), longint'($urandom_range(0, 30 << 16)),
              pick(20) ? longint'($urandom) : longint'($urandom_range(0, 200 << 16)),
              longint'($urandom_range(0, 655360)), kd, longint'($urandom_range(1, 65536)), 1);
      idle_mode = p % 4;
      repeat (50) send_body(rand_body(), 0, STAT_INACTIVE);
      in_bus.valid = 1'b0;
    end

    idle_mode = IDLE_NONE;
    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[anchor_joint_constraint_unit.f]
sv/acju_pkg.sv
sv/acju_ifs.sv
sv/acju_isqrt.sv
sv/acju_fdiv.sv
sv/acju_core.sv
sv/anchor_joint_constraint_unit.sv
sv/acju_checker.sv
verif/tb_top.sv
